// File: hw/rtl/mf5_pkg.sv
package mf5_pkg;

    // window geometry and sample width
    localparam int WIN = 5;
    localparam int DW  = 8;

    // output queue depth
    localparam int FIFO_DEPTH = 8;
    localparam int FIFO_AW    = 3;

    // configuration register indexes
    typedef enum logic [1:0] {
        CFG_IMAGE_WIDTH   = 2'd0,
        CFG_IMAGE_HEIGHT  = 2'd1,
        CFG_CHANNEL_COUNT = 2'd2,
        CFG_UNUSED        = 2'd3
    } t_cfg_index;

    // input opcodes
    localparam logic OP_SAMPLE = 1'b0;
    localparam logic OP_DRAIN  = 1'b1;

    // per-position control travelling with the window pipeline
    typedef struct packed {
        logic                  emit;
        logic                  row_end;
        logic                  frame_end;
        logic [WIN-1:0]        col_ok;
        logic [WIN-1:0]        tap_smp;
        logic [WIN-1:0][1:0]   tap_line;
        logic [DW-1:0]         sample;
    } t_meta;

    // one result item
    typedef struct packed {
        logic          frame_end;
        logic          row_end;
        logic [DW-1:0] value;
    } t_result;

endpackage

// File: hw/rtl/mf5_line_store.sv
module mf5_line_store #(
    parameter int LINE_BYTES = 8192
) (
    input  logic                          i_clk,
    input  logic                          i_rd_en,
    input  logic [$clog2(LINE_BYTES)-1:0] i_addr,
    input  logic                          i_wr_en,
    input  logic [1:0]                    i_wr_lane,
    input  logic [7:0]                    i_wr_data,
    output logic [31:0]                   o_rd_data
);
    // four lines side by side, one byte lane per line
    logic [31:0] r_mem [LINE_BYTES];

    // read-first port, byte-lane write of the current row
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            o_rd_data <= r_mem[i_addr];
        end
        if (i_wr_en) begin
            r_mem[i_addr][{i_wr_lane, 3'b000} +: 8] <= i_wr_data;
        end
    end
endmodule

// File: hw/rtl/mf5_window.sv
module mf5_window #(
    parameter int MAX_CHANNELS = 4
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    input  mf5_pkg::t_meta  i_meta,
    input  logic [31:0]     i_line_word,
    input  logic [2:0]      i_step,
    output logic [1:0]      o_pend,
    output logic            o_valid,
    output mf5_pkg::t_result o_result
);
    import mf5_pkg::*;

    localparam int CHAIN = WIN * MAX_CHANNELS;

    logic [DW-1:0] r_win [WIN][CHAIN];
    logic [DW-1:0] n_tap [WIN];
    logic          r_v2, r_v3;
    t_meta         r_meta2, r_meta3;
    logic [DW-1:0] r_cmin [WIN];
    logic [DW-1:0] r_cmax [WIN];
    logic [DW-1:0] n_cmin [WIN];
    logic [DW-1:0] n_cmax [WIN];
    logic [DW-1:0] s_mn, s_mx;
    logic [DW:0]   s_sum;

    // new column of taps: line store or the incoming sample
    always_comb begin
        for (int t = 0; t < WIN; t++) begin
            if (i_meta.tap_smp[t]) begin
                n_tap[t] = i_meta.sample;
            end else begin
                n_tap[t] = i_line_word[{i_meta.tap_line[t], 3'b000} +: 8];
            end
        end
    end

    // shift chains, one per window row
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int t = 0; t < WIN; t++) begin
                for (int i = 0; i < CHAIN; i++) begin
                    r_win[t][i] <= '0;
                end
            end
        end else if (i_valid) begin
            for (int t = 0; t < WIN; t++) begin
                r_win[t][0] <= n_tap[t];
                for (int i = 1; i < CHAIN; i++) begin
                    r_win[t][i] <= r_win[t][i-1];
                end
            end
        end
    end

    // per-column min and max, columns spaced by the channel stride
    always_comb begin
        logic [DW-1:0] v;
        v = '0;
        for (int hh = 0; hh < WIN; hh++) begin
            n_cmin[hh] = '1;
            n_cmax[hh] = '0;
            for (int t = 0; t < WIN; t++) begin
                v = r_win[t][0];
                for (int s = 1; s <= MAX_CHANNELS; s++) begin
                    if (i_step == 3'(s)) begin
                        v = r_win[t][(WIN-1-hh)*s];
                    end
                end
                if (r_meta2.col_ok[hh]) begin
                    if (v < n_cmin[hh]) n_cmin[hh] = v;
                    if (v > n_cmax[hh]) n_cmax[hh] = v;
                end
            end
        end
    end

    // stage registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            r_v2 <= i_valid;
            r_v3 <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        r_meta2 <= i_meta;
        r_meta3 <= r_meta2;
        for (int hh = 0; hh < WIN; hh++) begin
            r_cmin[hh] <= n_cmin[hh];
            r_cmax[hh] <= n_cmax[hh];
        end
    end

    // reduce columns and round the midpoint
    always_comb begin
        s_mn = '1;
        s_mx = '0;
        for (int hh = 0; hh < WIN; hh++) begin
            if (r_cmin[hh] < s_mn) s_mn = r_cmin[hh];
            if (r_cmax[hh] > s_mx) s_mx = r_cmax[hh];
        end
        s_sum = {1'b0, s_mn} + {1'b0, s_mx} + 9'd1;
    end

    assign o_valid            = r_v3 && r_meta3.emit;
    assign o_result.value     = s_sum[DW:1];
    assign o_result.row_end   = r_meta3.row_end;
    assign o_result.frame_end = r_meta3.frame_end;
    assign o_pend             = {1'b0, r_v2} + {1'b0, r_v3};
endmodule

// File: hw/rtl/mf5_out_fifo.sv
module mf5_out_fifo (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  mf5_pkg::t_result i_data,
    output logic             o_valid,
    input  logic             i_ready,
    output mf5_pkg::t_result o_data,
    output logic [mf5_pkg::FIFO_AW:0] o_count
);
    import mf5_pkg::*;

    t_result              r_mem [FIFO_DEPTH];
    logic [FIFO_AW-1:0]   r_wr, r_rd;
    logic [FIFO_AW:0]     r_count;
    logic                 s_pop;

    assign s_pop   = o_valid && i_ready;
    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rd];
    assign o_count = r_count;

    // storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    // pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) r_wr <= r_wr + 1'b1;
            if (s_pop)  r_rd <= r_rd + 1'b1;
            if (i_push && !s_pop) begin
                r_count <= r_count + 1'b1;
            end else if (!i_push && s_pop) begin
                r_count <= r_count - 1'b1;
            end
        end
    end
endmodule

// File: hw/rtl/midpoint_filter_5x5.sv
// 5x5 midpoint filter, replicated borders, interleaved channels.
// Throughput: one sample per clock if the queue has room; tready stays low for the
// clock after a config write and during a drain. The first drain request of a frame
// with fewer than three rows walks up to one row plus 2*channels+1 positions, one per
// clock if the queue has room, to its result. Path: line read, window shift, reduce.
// Reset: synchronous active-low; 640x480x1, counters and queue clear, line store kept.
module midpoint_filter_5x5 #(
    parameter int LINE_BYTES   = 8192,
    parameter int MAX_CHANNELS = 4
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // config write port
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic [12:0] i_cfg_data,
    // slave side
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] sample
    input  logic        s_axis_tuser,   // [0] opcode
    // master side
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,   // [7:0] filtered_sample
    output logic        m_axis_tlast,   // row_end
    output logic        m_axis_tuser    // [0] frame_end
);
    import mf5_pkg::*;

    localparam int AW = $clog2(LINE_BYTES);
    localparam logic [15:0] SZ1 = 16'(LINE_BYTES);
    localparam logic [15:0] SZ2 = 16'((LINE_BYTES / 2) * 2);
    localparam logic [15:0] SZ3 = 16'((LINE_BYTES / 3) * 3);
    localparam logic [15:0] SZ4 = 16'((LINE_BYTES / 4) * 4);

    // config registers and effective geometry
    logic [11:0] r_cfg_width;
    logic [12:0] r_cfg_height;
    logic [2:0]  r_cfg_chan;
    logic        r_cfg_hold;
    logic [2:0]  r_step, n_step;
    logic [15:0] r_size, n_size;
    logic [12:0] r_height, n_height;

    // stream position
    logic [12:0] r_row, n_row;
    logic [15:0] r_col, n_col;
    logic        r_drain;

    // stage 1
    logic        r_v1;
    t_meta       r_meta1, n_meta;

    logic [31:0]       s_word;
    logic [1:0]        s_pend;
    logic              s_res_valid;
    t_result           s_result, s_out;
    logic [FIFO_AW:0]  s_count;

    logic        s_room, s_accept, s_gen, s_real;
    logic        s_is_smp, s_in_full;
    logic [15:0] s_two, s_one, s_k, s_wr;
    logic [12:0] s_rr;
    logic [11:0] s_w;
    logic [14:0] s_prod;
    logic        s_cge;

    // effective register values
    always_comb begin
        logic [15:0] cap;
        n_step = r_cfg_chan;
        if (r_cfg_chan == 3'd0) n_step = 3'd1;
        if (r_cfg_chan > 3'(MAX_CHANNELS)) n_step = 3'(MAX_CHANNELS);
        s_w = (r_cfg_width < 12'd5) ? 12'd5 : r_cfg_width;
        s_prod = {3'd0, s_w} * {12'd0, n_step};
        case (n_step)
            3'd2:    cap = SZ2;
            3'd3:    cap = SZ3;
            3'd4:    cap = SZ4;
            default: cap = SZ1;
        endcase
        n_size = ({1'b0, s_prod} > SZ1) ? cap : {1'b0, s_prod};
        n_height = r_cfg_height;
        if (r_cfg_height == 13'd0) n_height = 13'd1;
        if (r_cfg_height > 13'd4096) n_height = 13'd4096;
    end

    // config write; effective values are registered from the config registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_width  <= 12'd640;
            r_cfg_height <= 13'd480;
            r_cfg_chan   <= 3'd1;
            r_cfg_hold   <= 1'b0;
            r_step       <= 3'd1;
            r_size       <= 16'd640;
            r_height     <= 13'd480;
        end else begin
            if (i_cfg_we) begin
                unique case (t_cfg_index'(i_cfg_index))
                    CFG_IMAGE_WIDTH:   r_cfg_width  <= i_cfg_data[11:0];
                    CFG_IMAGE_HEIGHT:  r_cfg_height <= i_cfg_data;
                    CFG_CHANNEL_COUNT: r_cfg_chan   <= i_cfg_data[2:0];
                    default: ;
                endcase
            end
            r_cfg_hold <= i_cfg_we;
            r_step     <= n_step;
            r_size     <= n_size;
            r_height   <= n_height;
        end
    end

    // request handling and position generation
    assign s_room        = ({1'b0, s_count} + {4'd0, r_v1} + {3'd0, s_pend}) < 5'(FIFO_DEPTH);
    assign s_axis_tready = s_room && !r_drain && !r_cfg_hold;
    assign s_accept      = s_axis_tvalid && s_axis_tready;
    assign s_is_smp      = (s_axis_tuser == OP_SAMPLE);
    assign s_in_full     = ({3'd0, r_row} >= {3'd0, r_height});
    assign s_real        = s_accept && s_is_smp && !s_in_full;
    assign s_gen         = s_real || (s_accept && !s_is_smp && s_in_full)
                           || (r_drain && s_room);

    // window position decode
    always_comb begin
        logic signed [14:0] q;
        logic [12:0]        qc;
        s_one = {13'd0, r_step};
        s_two = {12'd0, r_step, 1'b0};
        s_cge = (r_col >= s_two);
        s_k   = s_cge ? (r_col - s_two) : (r_col + r_size - s_two);
        s_rr  = s_cge ? (r_row - 13'd2) : (r_row - 13'd3);
        n_meta.emit      = s_cge ? (r_row >= 13'd2) : (r_row >= 13'd3);
        n_meta.row_end   = (s_k == r_size - 16'd1);
        n_meta.frame_end = n_meta.row_end && (s_rr == r_height - 13'd1);
        n_meta.col_ok[0] = (s_k >= s_two);
        n_meta.col_ok[1] = (s_k >= s_one);
        n_meta.col_ok[2] = 1'b1;
        n_meta.col_ok[3] = ((s_k + s_one) < r_size);
        n_meta.col_ok[4] = ((s_k + s_two) < r_size);
        n_meta.sample    = s_axis_tdata;
        for (int t = 0; t < WIN; t++) begin
            q = $signed({2'b00, r_row}) - 15'sd4 + 15'(t);
            if (q < 15'sd0) begin
                qc = 13'd0;
            end else if (q > $signed({2'b00, r_height - 13'd1})) begin
                qc = r_height - 13'd1;
            end else begin
                qc = q[12:0];
            end
            n_meta.tap_line[t] = qc[1:0];
            n_meta.tap_smp[t]  = s_real && (qc == r_row);
        end
    end

    // next position
    always_comb begin
        s_wr  = r_col + 16'd1;
        n_row = r_row;
        n_col = r_col;
        if (s_gen) begin
            if (n_meta.emit && n_meta.frame_end) begin
                n_row = '0;
                n_col = '0;
            end else if (s_wr >= r_size) begin
                n_col = '0;
                n_row = r_row + 13'd1;
            end else begin
                n_col = s_wr;
            end
        end
    end

    // position counters and drain state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row   <= '0;
            r_col   <= '0;
            r_drain <= 1'b0;
            r_v1    <= 1'b0;
        end else begin
            if (i_cfg_we && (t_cfg_index'(i_cfg_index) != CFG_UNUSED)) begin
                r_row <= '0;
                r_col <= '0;
            end else begin
                r_row <= n_row;
                r_col <= n_col;
            end
            if (s_gen && !s_real) begin
                r_drain <= !n_meta.emit;
            end
            r_v1 <= s_gen;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_gen) begin
            r_meta1 <= n_meta;
        end
    end

    mf5_line_store #(
        .LINE_BYTES (LINE_BYTES)
    ) u_line (
        .i_clk      (i_clk),
        .i_rd_en    (s_gen),
        .i_addr     (r_col[AW-1:0]),
        .i_wr_en    (s_real),
        .i_wr_lane  (r_row[1:0]),
        .i_wr_data  (s_axis_tdata),
        .o_rd_data  (s_word)
    );

    mf5_window #(
        .MAX_CHANNELS (MAX_CHANNELS)
    ) u_win (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (r_v1),
        .i_meta      (r_meta1),
        .i_line_word (s_word),
        .i_step      (r_step),
        .o_pend      (s_pend),
        .o_valid     (s_res_valid),
        .o_result    (s_result)
    );

    mf5_out_fifo u_fifo (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (s_res_valid),
        .i_data   (s_result),
        .o_valid  (m_axis_tvalid),
        .i_ready  (m_axis_tready),
        .o_data   (s_out),
        .o_count  (s_count)
    );

    assign m_axis_tdata = s_out.value;
    assign m_axis_tlast = s_out.row_end;
    assign m_axis_tuser = s_out.frame_end;
endmodule

// File: test/tb_midpoint_filter_5x5.sv
module tb_midpoint_filter_5x5;
    timeunit 1ns;
    timeprecision 1ps;

    import mf5_pkg::*;

    localparam int LINE_SZ = 8192;
    localparam int CHAIN   = 20;

    // midpoint predictor and queue of expected filtered samples
    class midpoint_scoreboard;
        logic [7:0]  line_mem [4*LINE_SZ];
        logic [7:0]  taps [WIN][CHAIN];
        int unsigned in_col, in_row;
        logic [11:0] width_reg;
        logic [12:0] height_reg;
        logic [2:0]  chan_reg;
        t_result     pending [$];
        int          mismatches;

        function new();
            foreach (line_mem[i]) line_mem[i] = '0;
            foreach (taps[t, i]) taps[t][i] = '0;
            width_reg  = 12'd640;
            height_reg = 13'd480;
            chan_reg   = 3'd1;
            in_col     = 0;
            in_row     = 0;
            mismatches = 0;
        endfunction

        function void write_reg(t_cfg_index idx, logic [12:0] val);
            case (idx)
                CFG_IMAGE_WIDTH:   width_reg = val[11:0];
                CFG_IMAGE_HEIGHT:  height_reg = val;
                CFG_CHANNEL_COUNT: chan_reg = val[2:0];
                default: return;
            endcase
            in_col = 0;
            in_row = 0;
        endfunction

        // effective stride, row size in samples and frame height
        function void geometry(output int unsigned stp, output int unsigned size,
                               output int unsigned h);
            int unsigned w;
            stp = (chan_reg == 0) ? 1 : ((chan_reg > 4) ? 4 : chan_reg);
            w = (width_reg < 5) ? 5 : width_reg;
            if (w * stp > LINE_SZ) w = LINE_SZ / stp;
            size = w * stp;
            h = (height_reg < 1) ? 1 : ((height_reg > 4096) ? 4096 : height_reg);
        endfunction

        // one stream position, real sample or virtual drain position
        function bit advance(bit is_real, logic [7:0] smp, output t_result res);
            int unsigned stp, size, h, r, c, cm, orow, k, base, d;
            int q, j, mn, mx;
            bit emit;
            logic [7:0] v;
            geometry(stp, size, h);
            r = in_row;
            c = in_col;
            cm = c % LINE_SZ;
            emit = 0;
            res = '0;
            for (int t = 0; t < WIN; t++) begin
                q = int'(r) - 4 + t;
                if (q < 0) q = 0;
                if (q > int'(h) - 1) q = int'(h) - 1;
                if (is_real && q == int'(r)) v = smp;
                else v = line_mem[(q & 3) * LINE_SZ + cm];
                for (int i = CHAIN - 1; i > 0; i--) taps[t][i] = taps[t][i-1];
                taps[t][0] = v;
            end
            if (is_real) line_mem[(r & 3) * LINE_SZ + cm] = smp;
            if (c >= 2 * stp) begin
                if (r >= 2) begin
                    emit = 1; orow = r - 2; k = c - 2 * stp; base = c;
                end
            end else if (r >= 3) begin
                emit = 1; orow = r - 3; k = c + size - 2 * stp; base = c + size;
            end
            c++;
            if (c >= size) begin
                c = 0;
                r++;
            end
            in_col = c;
            in_row = r;
            if (!emit) return 0;
            mn = 255;
            mx = 0;
            for (int hh = 0; hh < WIN; hh++) begin
                j = int'(k) + (hh - 2) * int'(stp);
                if (j < 0 || j >= int'(size)) continue;
                d = base - j;
                if (d >= CHAIN) continue;
                for (int t = 0; t < WIN; t++) begin
                    if (taps[t][d] < mn) mn = taps[t][d];
                    if (taps[t][d] > mx) mx = taps[t][d];
                end
            end
            res.value = 8'((mn + mx + 1) >> 1);
            res.row_end = (k == size - 1);
            res.frame_end = (k == size - 1) && (orow == h - 1);
            if (res.frame_end) begin
                in_col = 0;
                in_row = 0;
            end
            return 1;
        endfunction

        // note an accepted request, returns 1 when it ends the frame
        function bit note_input(logic op, logic [7:0] smp);
            int unsigned stp, size, h;
            t_result res;
            bit got;
            geometry(stp, size, h);
            got = 0;
            if (op == OP_SAMPLE) begin
                if (in_row >= h) return 0;
                got = advance(1, smp, res);
            end else begin
                if (in_row < h) return 0;
                for (int n = 0; n < 4 * LINE_SZ + 64; n++) begin
                    got = advance(0, 8'd0, res);
                    if (got) break;
                end
            end
            if (!got) return 0;
            pending.push_back(res);
            return res.frame_end;
        endfunction

        function void check_result(t_result got);
            t_result want;
            if (pending.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result value=%0d row_end=%0b frame_end=%0b",
                             got.value, got.row_end, got.frame_end);
                return;
            end
            want = pending.pop_front();
            if (got.value !== want.value || got.row_end !== want.row_end ||
                got.frame_end !== want.frame_end) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("mismatch exp %0d/%0b/%0b got %0d/%0b/%0b",
                             want.value, want.row_end, want.frame_end,
                             got.value, got.row_end, got.frame_end);
            end
        endfunction
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic [1:0]  i_cfg_index;
    logic [12:0] i_cfg_data;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata;
    logic        s_axis_tuser;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [7:0]  m_axis_tdata;
    logic        m_axis_tlast;
    logic        m_axis_tuser;

    midpoint_filter_5x5 uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_we), .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata), .m_axis_tlast(m_axis_tlast),
        .m_axis_tuser(m_axis_tuser)
    );

    midpoint_scoreboard sb = new();
    bit send_gaps = 1;
    bit recv_gaps = 1;
    bit hold_req  = 0;
    int rand_items = 0;

    // clock
    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // run limit
    initial begin
        #60_000_000;
        $display("status: fail");
        $finish;
    end

    // result checker
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready)
            sb.check_result('{frame_end: m_axis_tuser, row_end: m_axis_tlast,
                              value: m_axis_tdata});
    end

    // receiver with random stalls and one long hold-off
    initial begin
        int gap;
        m_axis_tready <= 1'b0;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if (hold_req) begin
                m_axis_tready <= 1'b0;
                repeat (400) @(posedge i_clk);
                hold_req = 0;
            end
            gap = recv_gaps ? $urandom_range(0, 9) : 0;
            if (gap > 0) begin
                m_axis_tready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            m_axis_tready <= 1'b1;
            do @(posedge i_clk); while (!m_axis_tvalid);
        end
    end

    // offer one request and note it once accepted
    task automatic send(logic op, logic [7:0] smp, output bit done);
        int gap;
        gap = send_gaps ? $urandom_range(0, 9) : 0;
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= op;
        s_axis_tdata  <= smp;
        do @(posedge i_clk); while (!s_axis_tready);
        done = sb.note_input(op, smp);
    endtask

    // wait until every expected result has arrived, then let the block settle
    task automatic wait_idle();
        s_axis_tvalid <= 1'b0;
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
    endtask

    task automatic write_cfg(t_cfg_index idx, logic [12:0] val);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        sb.write_reg(idx, val);
    endtask

    task automatic set_frame(logic [12:0] w, logic [12:0] h, logic [12:0] c);
        wait_idle();
        write_cfg(CFG_IMAGE_WIDTH, w);
        write_cfg(CFG_IMAGE_HEIGHT, h);
        write_cfg(CFG_CHANNEL_COUNT, c);
    endtask

    // one frame of random samples, optional noise, then drains to the end
    task automatic run_frame(bit noisy);
        int unsigned stp, size, h;
        bit done;
        sb.geometry(stp, size, h);
        done = 0;
        for (int unsigned n = 0; n < size * h; n++) begin
            if (noisy && $urandom_range(0, 19) == 0) send(OP_DRAIN, 8'($urandom), done);
            send(OP_SAMPLE, 8'($urandom), done);
            rand_items++;
        end
        if (noisy && $urandom_range(0, 2) == 0)
            repeat ($urandom_range(1, 3)) send(OP_SAMPLE, 8'($urandom), done);
        while (!done) begin
            send(OP_DRAIN, 8'($urandom), done);
            rand_items++;
        end
    endtask

    // stimulus
    initial begin
        bit done;
        int cnt;
        i_rst_n       <= 1'b0;
        i_cfg_we      <= 1'b0;
        i_cfg_index   <= CFG_IMAGE_WIDTH;
        i_cfg_data    <= '0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tuser  <= OP_SAMPLE;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: smallest frame, extreme samples, early drain, extra samples
        set_frame(13'd5, 13'd1, 13'd1);
        send(OP_DRAIN, 8'hff, done);
        send(OP_SAMPLE, 8'h00, done);
        send(OP_SAMPLE, 8'hff, done);
        send(OP_SAMPLE, 8'h00, done);
        send(OP_SAMPLE, 8'hff, done);
        send(OP_SAMPLE, 8'h80, done);
        send(OP_SAMPLE, 8'h7f, done);
        send(OP_SAMPLE, 8'h55, done);
        while (!done) send(OP_DRAIN, 8'h00, done);
        // unused register index does nothing
        wait_idle();
        write_cfg(CFG_UNUSED, 13'h1fff);

        // out-of-range registers
        set_frame(13'd0, 13'd0, 13'd0);
        run_frame(0);
        set_frame(13'd3, 13'd4, 13'd7);
        run_frame(1);
        set_frame(13'd6, 13'd3, 13'd4);
        run_frame(1);

        // frame without idling
        send_gaps = 0;
        recv_gaps = 0;
        set_frame(13'd20, 13'd2, 13'd1);
        run_frame(0);

        // long receiver hold-off while samples keep coming
        set_frame(13'd16, 13'd3, 13'd1);
        hold_req = 1;
        run_frame(0);
        send_gaps = 1;
        recv_gaps = 1;

        // random frames, mostly small
        rand_items = 0;
        cnt = 0;
        while (rand_items < 120) begin
            if ($urandom_range(0, 7) == 0)
                set_frame(13'($urandom_range(0, 4)), 13'($urandom_range(0, 2)),
                          13'($urandom_range(0, 7)));
            else
                set_frame(13'($urandom_range(5, 12)), 13'($urandom_range(1, 6)),
                          13'($urandom_range(1, 4)));
            send_gaps = ($urandom_range(0, 3) != 0);
            recv_gaps = ($urandom_range(0, 3) != 0);
            repeat ($urandom_range(1, 2)) run_frame($urandom_range(0, 1));
            cnt++;
        end
        send_gaps = 1;
        recv_gaps = 1;
        s_axis_tvalid <= 1'b0;

        // drain and finish
        cnt = 0;
        while (sb.pending.size() != 0 && cnt < 100000) begin
            @(posedge i_clk);
            cnt++;
        end
        repeat (50) @(posedge i_clk);
        if (sb.mismatches == 0 && sb.pending.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

// File: sim.f
hw/rtl/mf5_pkg.sv
hw/rtl/mf5_line_store.sv
hw/rtl/mf5_window.sv
hw/rtl/mf5_out_fifo.sv
hw/rtl/midpoint_filter_5x5.sv
test/tb_midpoint_filter_5x5.sv
